### rtl/wsfd_pkg.sv
// Types, constants and the CRC byte step shared by the wind sensor frame decoder.
package wsfd_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_BASE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_DEADBAND = 2'd2;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] DEADBAND_RESET = 16'd3;

  // sector = ((4*deg + 45) / 90) % 16 + 1, the divide done as x * ceil(2^32/90) >> 32
  localparam logic [17:0] SECT_BIAS  = 18'd45;
  localparam logic [25:0] SECT_RECIP = 26'd47721859;
  localparam int unsigned SECT_SHIFT = 32;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       first_byte;
    logic       sensor_kind;
    logic       calibrate;
  } in_t;

  typedef struct packed {
    logic        crc_ok;
    logic        reading_kind;
    logic [15:0] speed_out;
    logic [4:0]  sector_out;
    logic [15:0] degree_out;
  } out_t;

  // completed frame, handed from the frame tracker to the correction stage
  typedef struct packed {
    logic        ok;
    logic        kind;
    logic        cal;
    logic [15:0] reading;
  } job_t;

  typedef enum logic [1:0] {
    SEC_KEEP,
    SEC_ZERO,
    SEC_CALC
  } sector_op_t;

  // corrected values, handed from the correction stage to the sector stage
  typedef struct packed {
    logic        ok;
    logic        kind;
    logic [15:0] speed;
    logic [15:0] degree;
    sector_op_t  op;
  } mid_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### rtl/wsfd_frame_tracker.sv
// Frame tracker: byte position, running CRC, reading bytes and CRC check.
module wsfd_frame_tracker #(
  parameter int unsigned CRC_BYTES = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  wsfd_pkg::in_t din,
  output logic          job_v,
  output wsfd_pkg::job_t job
);

  localparam logic [2:0] LAST_IDX = 3'(CRC_BYTES + 1);
  localparam logic [2:0] DATA_END = 3'(CRC_BYTES);

  logic        active_r, active_nxt;
  logic [2:0]  count_r, count_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  high_r, high_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [7:0]  crc_low_r, crc_low_nxt;

  logic        open;
  logic [2:0]  idx;
  logic [15:0] crc_base;
  logic [7:0]  high_base;
  logic [7:0]  low_base;

  always_comb begin
    open      = din.first_byte || active_r;
    idx       = din.first_byte ? 3'd0 : count_r;
    crc_base  = din.first_byte ? wsfd_pkg::CRC_INIT : crc_r;
    high_base = din.first_byte ? 8'h00 : high_r;
    low_base  = din.first_byte ? 8'h00 : low_r;

    active_nxt  = active_r;
    count_nxt   = count_r;
    crc_nxt     = crc_r;
    high_nxt    = high_r;
    low_nxt     = low_r;
    crc_low_nxt = crc_low_r;
    job_v       = 1'b0;

    if (accept && open) begin
      active_nxt = 1'b1;
      crc_nxt    = crc_base;
      high_nxt   = high_base;
      low_nxt    = low_base;
      if (idx < DATA_END) begin
        crc_nxt = wsfd_pkg::crc16_byte(crc_base, din.rx_byte);
        if (idx == 3'd3) begin
          high_nxt = din.rx_byte;
        end
        if (idx == 3'd4) begin
          low_nxt = din.rx_byte;
        end
        count_nxt = idx + 3'd1;
      end else if (idx == DATA_END) begin
        crc_low_nxt = din.rx_byte;
        count_nxt   = idx + 3'd1;
      end else begin
        active_nxt = 1'b0;
        count_nxt  = 3'd0;
        job_v      = 1'b1;
      end
    end

    job.ok      = ({din.rx_byte, crc_low_r} == crc_base);
    job.kind    = din.sensor_kind;
    job.cal     = din.calibrate;
    job.reading = {high_base, low_base};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      count_r   <= 3'd0;
      crc_r     <= wsfd_pkg::CRC_INIT;
      high_r    <= 8'h00;
      low_r     <= 8'h00;
      crc_low_r <= 8'h00;
    end else begin
      active_r  <= active_nxt;
      count_r   <= count_nxt;
      crc_r     <= crc_nxt;
      high_r    <= high_nxt;
      low_r     <= low_nxt;
      crc_low_r <= crc_low_nxt;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LAST_IDX)
    else $error("byte position past end of frame");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    job_v |=> !active_r && count_r == 3'd0)
    else $error("frame still open after last byte");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> count_r == 3'd0)
    else $error("byte position kept with no open frame");

endmodule

### rtl/wsfd_correct.sv
// Correction stage: offsets, saturation, dead band, calm rule and calibration.
module wsfd_correct (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           advance,
  input  wsfd_pkg::job_t job,
  input  logic [15:0]    speed_base,
  input  logic [15:0]    direction_base,
  input  logic [15:0]    speed_dead_band,
  output wsfd_pkg::mid_t mid
);

  logic [15:0]        speed_r, speed_nxt;
  logic [15:0]        degree_r, degree_nxt;
  logic signed [16:0] speed_off_r, speed_off_nxt;
  logic signed [16:0] dir_off_r, dir_off_nxt;

  logic signed [16:0] off_sel;
  logic signed [17:0] sum;
  logic [15:0]        corr;
  logic [15:0]        base_sel;
  logic signed [18:0] off_sum;
  logic signed [16:0] off_new;

  always_comb begin
    off_sel = job.kind ? dir_off_r : speed_off_r;
    sum     = $signed({2'b00, job.reading}) + $signed({off_sel[16], off_sel});
    if (sum[17]) begin
      corr = 16'h0000;
    end else if (sum[16]) begin
      corr = 16'hFFFF;
    end else begin
      corr = sum[15:0];
    end

    base_sel = job.kind ? direction_base : speed_base;
    off_sum  = $signed({{2{off_sel[16]}}, off_sel}) + $signed({3'b000, base_sel})
               - $signed({3'b000, corr});
    if (off_sum[18:16] == 3'b000 || off_sum[18:16] == 3'b111) begin
      off_new = off_sum[16:0];
    end else if (off_sum[18]) begin
      off_new = 17'sh10000;
    end else begin
      off_new = 17'sh0FFFF;
    end

    speed_nxt     = speed_r;
    degree_nxt    = degree_r;
    speed_off_nxt = speed_off_r;
    dir_off_nxt   = dir_off_r;
    mid.op        = wsfd_pkg::SEC_KEEP;

    if (job.ok) begin
      if (!job.kind) begin
        speed_nxt = corr;
        if (job.cal) begin
          speed_off_nxt = off_new;
        end else if (corr < speed_dead_band) begin
          speed_nxt = 16'h0000;
        end
      end else begin
        degree_nxt = corr;
        mid.op     = wsfd_pkg::SEC_CALC;
        if (job.cal) begin
          dir_off_nxt = off_new;
        end else if (speed_r == 16'h0000) begin
          degree_nxt = 16'h0000;
          mid.op     = wsfd_pkg::SEC_ZERO;
        end
      end
    end

    mid.ok     = job.ok;
    mid.kind   = job.kind;
    mid.speed  = speed_nxt;
    mid.degree = degree_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r     <= 16'h0000;
      degree_r    <= 16'h0000;
      speed_off_r <= 17'sd0;
      dir_off_r   <= 17'sd0;
    end else if (advance) begin
      speed_r     <= speed_nxt;
      degree_r    <= degree_nxt;
      speed_off_r <= speed_off_nxt;
      dir_off_r   <= dir_off_nxt;
    end
  end

  a_bad_crc_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !job.ok |=> $stable(speed_r) && $stable(degree_r)
      && $stable(speed_off_r) && $stable(dir_off_r))
    else $error("values changed on a failed CRC");

  a_calm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    mid.op == wsfd_pkg::SEC_ZERO |-> mid.degree == 16'h0000 && speed_r == 16'h0000)
    else $error("calm rule applied with nonzero speed");

endmodule

### rtl/wind_sensor_frame_decoder_unit.sv
// Top level of the wind sensor reply frame decoder.
//
//   channel  dir  handshake              payload
//   in_      in   in_valid / in_ready    in_data  (wsfd_pkg::in_t, one byte)
//   out_     out  out_valid / out_ready  out_data (wsfd_pkg::out_t, one per frame)
//   cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data (16 bit)
//
// One byte is taken per cycle while in_ready is high. The result of a frame is
// registered behind the frame tracker, correction stage and sector stage in turn.
// The sector stage multiplies by a reciprocal of 90 and holds its own register.
// Reset clears frame state, offsets, values, bases; dead band 3; no clearing pass.
// A stalled output holds the stages behind it; in_ready falls only when all are full.
module wind_sensor_frame_decoder_unit #(
  parameter int unsigned CRC_BYTES = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  wsfd_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output wsfd_pkg::out_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wsfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                       cfg_data
);

  logic [15:0] speed_base_r;
  logic [15:0] direction_base_r;
  logic [15:0] dead_band_r;

  logic           accept;
  logic           job_v;
  wsfd_pkg::job_t job;

  logic           b_v_r, b_v_nxt;
  wsfd_pkg::job_t b_r;
  logic           b_hold, b_adv;
  wsfd_pkg::mid_t mid;

  logic           c_v_r, c_v_nxt;
  wsfd_pkg::mid_t c_r;
  logic           c_hold, c_adv;

  logic [4:0]     sector_r, sector_nxt;
  logic [18:0]    sect_x;
  logic [43:0]    sect_prod;
  logic [4:0]     sect_calc;

  logic           out_valid_r, out_valid_nxt;
  wsfd_pkg::out_t out_r, out_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_base_r     <= 16'h0000;
      direction_base_r <= 16'h0000;
      dead_band_r      <= wsfd_pkg::DEADBAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wsfd_pkg::CFG_SPEED_BASE:     speed_base_r     <= cfg_data;
        wsfd_pkg::CFG_DIRECTION_BASE: direction_base_r <= cfg_data;
        wsfd_pkg::CFG_SPEED_DEADBAND: dead_band_r      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    c_hold   = out_valid_r && !out_ready;
    c_adv    = c_v_r && !c_hold;
    b_hold   = c_v_r && c_hold;
    b_adv    = b_v_r && !b_hold;
    in_ready = !(b_v_r && b_hold);
    accept   = in_valid && in_ready;

    b_v_nxt       = (b_v_r && b_hold) || job_v;
    c_v_nxt       = (c_v_r && c_hold) || b_adv;
    out_valid_nxt = (out_valid_r && !out_ready) || c_adv;
  end

  wsfd_frame_tracker #(
    .CRC_BYTES(CRC_BYTES)
  ) u_frame (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(accept),
    .din   (in_data),
    .job_v (job_v),
    .job   (job)
  );

  wsfd_correct u_correct (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (b_adv),
    .job            (b_r),
    .speed_base     (speed_base_r),
    .direction_base (direction_base_r),
    .speed_dead_band(dead_band_r),
    .mid            (mid)
  );

  always_comb begin
    sect_x    = {1'b0, c_r.degree, 2'b00} + {1'b0, wsfd_pkg::SECT_BIAS};
    sect_prod = 44'(sect_x) * 44'(wsfd_pkg::SECT_RECIP);
    sect_calc = {1'b0, sect_prod[wsfd_pkg::SECT_SHIFT+3:wsfd_pkg::SECT_SHIFT]} + 5'd1;
    case (c_r.op)
      wsfd_pkg::SEC_CALC: sector_nxt = sect_calc;
      wsfd_pkg::SEC_ZERO: sector_nxt = 5'd0;
      default:            sector_nxt = sector_r;
    endcase
    out_nxt.crc_ok       = c_r.ok;
    out_nxt.reading_kind = c_r.kind;
    out_nxt.speed_out    = c_r.speed;
    out_nxt.sector_out   = sector_nxt;
    out_nxt.degree_out   = c_r.degree;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
      sector_r    <= 5'd0;
    end else begin
      b_v_r       <= b_v_nxt;
      c_v_r       <= c_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (c_adv) begin
        sector_r <= sector_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_v) begin
      b_r <= job;
    end
    if (b_adv) begin
      c_r <= mid;
    end
    if (c_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !b_v_r && !c_v_r)
    else $error("pipeline not empty after reset");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> b_v_r && c_v_r && out_valid_r)
    else $error("input stalled with room in the pipeline");

  a_c_holds: assert property (@(posedge clk) disable iff (!rst_n)
    c_v_r && c_hold |=> c_v_r && $stable(c_r))
    else $error("sector stage lost a held frame");

  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    c_adv |=> sector_r <= 5'd16)
    else $error("sector out of range");

endmodule
